// ===== rtl/core/wts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

    localparam int unsigned CodeWidth  = 16;
    localparam int unsigned ClassWidth = 3;
    localparam int unsigned CountWidth = 2;

    // Spacing class codes
    localparam logic [ClassWidth-1:0] ClassNone       = 3'd0;
    localparam logic [ClassWidth-1:0] ClassSpace      = 3'd1;
    localparam logic [ClassWidth-1:0] ClassManySpaces = 3'd2;
    localparam logic [ClassWidth-1:0] ClassNewline    = 3'd3;
    localparam logic [ClassWidth-1:0] ClassManyLines  = 3'd4;

    localparam logic [CountWidth-1:0] CountMax = 2'd2;

    // Newline code units
    localparam logic [CodeWidth-1:0] CuLineFeed  = 16'h000A;
    localparam logic [CodeWidth-1:0] CuLineSep   = 16'h2028;
    localparam logic [CodeWidth-1:0] CuParaSep   = 16'h2029;

    // One result transaction, before packing onto the bus
    typedef struct packed {
        logic [CodeWidth-1:0]  char_out;
        logic                  token_start;
        logic [ClassWidth-1:0] spacing_before;
        logic                  starts_sentence;
    } result_t;

    // Unicode White_Space within the basic plane
    function automatic logic is_white(input logic [CodeWidth-1:0] c);
        logic w;
        w = ((c >= 16'h0009) && (c <= 16'h000D))
            || (c == 16'h0020) || (c == 16'h0085) || (c == 16'h00A0)
            || (c == 16'h1680)
            || ((c >= 16'h2000) && (c <= 16'h200A))
            || (c == CuLineSep) || (c == CuParaSep) || (c == 16'h202F)
            || (c == 16'h205F) || (c == 16'h3000);
        return w;
    endfunction

    function automatic logic is_newline(input logic [CodeWidth-1:0] c);
        return (c == CuLineFeed) || (c == CuLineSep) || (c == CuParaSep);
    endfunction

    // Configured class, out-of-range codes fold to none
    function automatic logic [ClassWidth-1:0] init_class(
        input logic [ClassWidth-1:0] cfg
    );
        return (cfg > ClassManyLines) ? ClassNone : cfg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wts_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wts_in_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [wts_pkg::CodeWidth-1:0] s_code,
    input  wire logic                          s_mark,
    input  wire logic                          consume,
    output logic                               in_valid,
    output logic [wts_pkg::CodeWidth-1:0]      in_code,
    output logic                               in_mark
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [wts_pkg::CodeWidth-1:0] code_reg;
    logic                          mark_reg;

    // Slot is free when empty or when the core takes the held item this cycle
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            code_reg <= s_code;
            mark_reg <= s_mark;
        end
    end

    assign in_valid = valid_reg;
    assign in_code  = code_reg;
    assign in_mark  = mark_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wts_token_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wts_token_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wts_pkg::ClassWidth-1:0] cfg_wr_data,
    input  wire logic                           in_valid,
    input  wire logic [wts_pkg::CodeWidth-1:0]  in_code,
    input  wire logic                           in_mark,
    input  wire logic                           out_free,
    output logic                                consume,
    output logic                                res_valid,
    output wts_pkg::result_t                    result
);

    logic [wts_pkg::ClassWidth-1:0] init_class_reg;
    logic                           inside_reg;
    logic                           inside_next;
    logic                           nbs_reg;
    logic                           nbs_next;
    logic [wts_pkg::CountWidth-1:0] space_cnt_reg;
    logic [wts_pkg::CountWidth-1:0] space_cnt_next;
    logic [wts_pkg::CountWidth-1:0] nl_cnt_reg;
    logic [wts_pkg::CountWidth-1:0] nl_cnt_next;
    logic                           white;
    logic                           newline;
    logic [wts_pkg::ClassWidth-1:0] cls_init;
    logic [wts_pkg::ClassWidth-1:0] cls_ws;

    assign white    = wts_pkg::is_white(in_code);
    assign newline  = wts_pkg::is_newline(in_code);
    assign cls_init = wts_pkg::init_class(init_class_reg);

    // Whitespace never needs the output slot
    assign consume   = in_valid && (white || out_free);
    assign res_valid = consume && !white;

    // Class from the whitespace run before the token
    always_comb begin
        if (nl_cnt_reg >= wts_pkg::CountMax) begin
            cls_ws = wts_pkg::ClassManyLines;
        end else if (nl_cnt_reg != '0) begin
            cls_ws = wts_pkg::ClassNewline;
        end else if (space_cnt_reg >= wts_pkg::CountMax) begin
            cls_ws = wts_pkg::ClassManySpaces;
        end else if (space_cnt_reg != '0) begin
            cls_ws = wts_pkg::ClassSpace;
        end else begin
            cls_ws = cls_init;
        end
    end

    // Result fields
    always_comb begin
        result.char_out        = in_code;
        result.token_start     = 1'b0;
        result.spacing_before  = wts_pkg::ClassNone;
        result.starts_sentence = 1'b0;
        if (!inside_reg) begin
            result.token_start     = 1'b1;
            result.spacing_before  = cls_ws;
            result.starts_sentence = nbs_reg;
        end else if (in_mark) begin
            // marked unit splits the token
            result.token_start     = 1'b1;
            result.spacing_before  = cls_init;
            result.starts_sentence = 1'b1;
        end
    end

    // Token state update
    always_comb begin
        inside_next    = inside_reg;
        nbs_next       = nbs_reg;
        space_cnt_next = space_cnt_reg;
        nl_cnt_next    = nl_cnt_reg;
        if (consume) begin
            if (white) begin
                if (inside_reg) begin
                    nbs_next    = in_mark;
                    inside_next = 1'b0;
                end
                if (space_cnt_reg < wts_pkg::CountMax) begin
                    space_cnt_next = space_cnt_reg + 1'b1;
                end
                if (newline && (nl_cnt_reg < wts_pkg::CountMax)) begin
                    nl_cnt_next = nl_cnt_reg + 1'b1;
                end
            end else if (!inside_reg || in_mark) begin
                inside_next    = 1'b1;
                space_cnt_next = '0;
                nl_cnt_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_class_reg <= wts_pkg::ClassNone;
            inside_reg     <= 1'b0;
            nbs_reg        <= 1'b1;
            space_cnt_reg  <= '0;
            nl_cnt_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                init_class_reg <= cfg_wr_data;
            end
            inside_reg    <= inside_next;
            nbs_reg       <= nbs_next;
            space_cnt_reg <= space_cnt_next;
            nl_cnt_reg    <= nl_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wts_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wts_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             res_valid,
    input  wire wts_pkg::result_t result,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output wts_pkg::result_t      m_result
);

    logic             valid_reg;
    logic             valid_next;
    wts_pkg::result_t data_reg;

    // Slot is free when empty or being drained this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/whitespace_token_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Whitespace token splitter.
// Input stream: one UTF-16 code unit per transaction on s_tdata, with the
// sentence-boundary mark from an external segmenter on s_tuser.
// Output stream: every non-whitespace unit on m_tdata; m_tuser flags the
// first unit of a token with its spacing class and begins-sentence flag.
// Whitespace units produce no output transaction but update the counters.
// cfg_wr_en/cfg_wr_data write the initial spacing class; write only while
// the block is idle.
// Path: the input register, then the token state update, then the result
// register; m_tvalid rises once the unit is held in the result register.
// Throughput: one code unit per cycle while the receiver does not stall
// non-whitespace units, set by the token state update between the
// two registers.
// Reset (aresetn low, synchronous) empties both registers, clears the
// token state and the initial class, and arms begins-sentence for the
// first token.
// When the receiver stalls, the result register holds; the input register
// still takes one more unit, and whitespace units keep flowing since they
// need no output slot.
module whitespace_token_splitter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,  // initial_class
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // [15:0] code_unit
    input  wire logic        s_tuser,      // [0] sentence_mark
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // [15:0] char_out
    output logic [4:0]       m_tuser       // [0] token_start,
                                           // [3:1] spacing_before,
                                           // [4] starts_sentence
);

    logic                          consume;
    logic                          in_valid;
    logic [wts_pkg::CodeWidth-1:0] in_code;
    logic                          in_mark;
    logic                          out_free;
    logic                          res_valid;
    wts_pkg::result_t              result;
    wts_pkg::result_t              m_result;

    wts_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_code   (s_tdata),
        .s_mark   (s_tuser),
        .consume  (consume),
        .in_valid (in_valid),
        .in_code  (in_code),
        .in_mark  (in_mark)
    );

    wts_token_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_code     (in_code),
        .in_mark     (in_mark),
        .out_free    (out_free),
        .consume     (consume),
        .res_valid   (res_valid),
        .result      (result)
    );

    wts_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .result    (result),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result)
    );

    // Bus packing
    assign m_tdata = m_result.char_out;
    assign m_tuser = {m_result.starts_sentence, m_result.spacing_before,
                      m_result.token_start};

endmodule

`default_nettype wire
